// ----- rtl/pfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and codes for the protobuf field encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY = 1'd1;

    // Field type codes
    localparam logic [4:0] FT_DOUBLE   = 5'd0;
    localparam logic [4:0] FT_FLOAT    = 5'd1;
    localparam logic [4:0] FT_INT32    = 5'd2;
    localparam logic [4:0] FT_UINT32   = 5'd3;
    localparam logic [4:0] FT_SINT32   = 5'd4;
    localparam logic [4:0] FT_INT64    = 5'd5;
    localparam logic [4:0] FT_UINT64   = 5'd6;
    localparam logic [4:0] FT_SINT64   = 5'd7;
    localparam logic [4:0] FT_FIXED32  = 5'd8;
    localparam logic [4:0] FT_FIXED64  = 5'd9;
    localparam logic [4:0] FT_SFIXED32 = 5'd10;
    localparam logic [4:0] FT_SFIXED64 = 5'd11;
    localparam logic [4:0] FT_BOOL     = 5'd12;
    localparam logic [4:0] FT_ENUM     = 5'd13;
    localparam logic [4:0] FT_STRING   = 5'd14;
    localparam logic [4:0] FT_BYTES    = 5'd15;
    localparam logic [4:0] FT_MESSAGE  = 5'd16;

    // Wire type codes
    localparam logic [2:0] WT_VAR   = 3'd0;
    localparam logic [2:0] WT_FIX64 = 3'd1;
    localparam logic [2:0] WT_LEN   = 3'd2;
    localparam logic [2:0] WT_FIX32 = 3'd5;

    typedef enum logic [1:0] {
        K_VARINT,
        K_FIX64,
        K_LEN,
        K_FIX32
    } kind_t;

    // One classified field, handed from front to back
    typedef struct packed {
        logic        restart;
        logic        omit;
        kind_t       kind;
        logic [31:0] key;
        logic [63:0] value;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        last;
        logic        status;
        logic [31:0] used;
    } res_t;

    function automatic logic [2:0] kind_wire(kind_t k);
        logic [2:0] wt;
        case (k)
            K_VARINT: wt = WT_VAR;
            K_FIX64:  wt = WT_FIX64;
            K_LEN:    wt = WT_LEN;
            default:  wt = WT_FIX32;
        endcase
        return wt;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/protobuf_field_encoder.sv -----
// Path: an accepted field enters the command queue, is loaded from there by
// the byte sequencer once it is idle, and its results reach the result port
// through the result queue. Throughput: the sequencer emits one byte per cycle
// while the result queue has room, key bytes and then value bytes, and takes
// the next field only after it has finished the last one.
// Reset: rst_n asynchronous, clears both queues, the count and the registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_field_encoder
// Serializes protobuf fields (key and value) into bytes with a capacity check.
// ----------------------------------------------------------------------------
module protobuf_field_encoder
    import pfe_pkg::*;
#(
    parameter int RES_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 restart,
    input  wire logic [4:0]           field_type,
    input  wire logic [28:0]          field_number,
    input  wire logic                 omit_key,
    input  wire logic [63:0]          value_bits,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                out_byte,
    output logic                      byte_valid,
    output logic                      last,
    output logic                      status,
    output logic [31:0]               bytes_used
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res;
    logic res_push;
    logic res_full;
    res_t head;

    pfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .restart      (restart),
        .field_type   (field_type),
        .field_number (field_number),
        .omit_key     (omit_key),
        .value_bits   (value_bits),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    pfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    pfe_out_fifo #(
        .Depth (RES_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .empty (empty),
        .pop   (pop),
        .dout  (head)
    );

    assign out_byte   = head.data;
    assign byte_valid = head.valid;
    assign last       = head.last;
    assign status     = head.status;
    assign bytes_used = head.used;

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_cmd_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cmd_valid) |=> cmd_valid)
        else $error("accepted field missing from command queue");

    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.status) |-> (res.last && !res.valid))
        else $error("error result not marked final");
`endif

endmodule
`default_nettype wire

// ----- rtl/pfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_front
// Classifies incoming fields (wire type, key, coded value) and queues them.
// ----------------------------------------------------------------------------
module pfe_front
    import pfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        restart,
    input  wire logic [4:0]  field_type,
    input  wire logic [28:0] field_number,
    input  wire logic        omit_key,
    input  wire logic [63:0] value_bits,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  wire logic        cmd_pop
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    cmd_t            q_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    cmd_t        cmd_in;
    kind_t       kind;
    logic [63:0] wv;
    logic [31:0] lo;
    logic        do_push;
    logic        do_pop;

    assign lo = value_bits[31:0];

    always_comb
    begin
        case (field_type)
            FT_DOUBLE, FT_FIXED64, FT_SFIXED64:
            begin
                kind = K_FIX64;
                wv   = value_bits;
            end
            FT_INT32, FT_ENUM:
            begin
                kind = K_VARINT;
                wv   = {{32{lo[31]}}, lo};
            end
            FT_UINT32:
            begin
                kind = K_VARINT;
                wv   = {32'd0, lo};
            end
            FT_SINT32:
            begin
                kind = K_VARINT;
                wv   = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
            end
            FT_INT64, FT_UINT64:
            begin
                kind = K_VARINT;
                wv   = value_bits;
            end
            FT_SINT64:
            begin
                kind = K_VARINT;
                wv   = {value_bits[62:0], 1'b0} ^ {64{value_bits[63]}};
            end
            FT_BOOL:
            begin
                kind = K_VARINT;
                wv   = {56'd0, value_bits[7:0]};
            end
            FT_STRING, FT_BYTES, FT_MESSAGE:
            begin
                kind = K_LEN;
                wv   = value_bits;
            end
            FT_FLOAT, FT_FIXED32, FT_SFIXED32:
            begin
                kind = K_FIX32;
                wv   = {32'd0, lo};
            end
            default:
            begin
                // unknown type: four zero bytes
                kind = K_FIX32;
                wv   = 64'd0;
            end
        endcase
        cmd_in.restart = restart;
        cmd_in.omit    = omit_key;
        cmd_in.kind    = kind;
        cmd_in.key     = {field_number, kind_wire(kind)};
        cmd_in.value   = wv;
    end

    assign full      = (count_reg == CntW'(Depth));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pfe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_back
// Byte sequencer: emits key and value bytes one per cycle while the result
// queue has room, tracks the byte count and remaining room, reports overflow.
// ----------------------------------------------------------------------------
module pfe_back
    import pfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_pop,
    input  wire logic                 res_full,
    output logic                      res_push,
    output res_t                      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_VAL,
        S_FIX,
        S_ERR
    } state_t;

    function automatic state_t value_state(kind_t k);
        state_t s;
        case (k)
            K_VARINT, K_LEN: s = S_VAL;
            default:         s = S_FIX;
        endcase
        return s;
    endfunction

    state_t      state_reg,  state_next;
    kind_t       kind_reg,   kind_next;
    logic [63:0] sh_reg,     sh_next;
    logic [63:0] val_reg,    val_next;
    logic [3:0]  nfix_reg,   nfix_next;
    logic [31:0] used_reg,   used_next;
    logic [31:0] room_reg,   room_next;
    logic [31:0] cap_reg,    cap_next;
    logic        count_only_reg, count_only_next;

    logic [7:0]  varint_byte;
    logic        varint_done;
    logic [31:0] used_p1;
    logic [31:0] room_m1;
    logic        payload_fit;

    assign varint_byte = {|sh_reg[63:7], sh_reg[6:0]};
    assign varint_done = ~|sh_reg[63:7];
    assign used_p1     = used_reg + 32'd1;
    assign room_m1     = room_reg - 32'd1;
    assign payload_fit = (val_reg <= {32'd0, room_m1});

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sh_next         = sh_reg;
        val_next        = val_reg;
        nfix_next       = nfix_reg;
        used_next       = used_reg;
        room_next       = room_reg;
        cap_next        = cap_reg;
        count_only_next = count_only_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    kind_next = cmd.kind;
                    val_next  = cmd.value;
                    sh_next   = cmd.omit ? cmd.value : {32'd0, cmd.key};
                    nfix_next = (cmd.kind == K_FIX64) ? 4'd8 : 4'd4;
                    state_next = cmd.omit ? value_state(cmd.kind) : S_KEY;
                    if (cmd.restart)
                    begin
                        used_next = '0;
                        room_next = cap_reg;
                    end
                end
            end
            S_KEY, S_VAL:
            begin
                if (!res_full)
                begin
                    if (room_reg == '0)
                    begin
                        res.last   = 1'b1;
                        res.status = 1'b1;
                        res.used   = used_reg;
                        res_push   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        used_next  = used_p1;
                        room_next  = room_m1;
                        sh_next    = sh_reg >> 7;
                        res.data   = varint_byte;
                        res.valid  = 1'b1;
                        res.used   = used_p1;
                        res_push   = !count_only_reg;
                        if (varint_done)
                        begin
                            if (state_reg == S_KEY)
                            begin
                                sh_next    = val_reg;
                                state_next = value_state(kind_reg);
                            end
                            else if (kind_reg == K_LEN && !payload_fit)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                // final byte; length fields also reserve the payload
                                if (kind_reg == K_LEN)
                                begin
                                    used_next = used_p1 + val_reg[31:0];
                                    room_next = room_m1 - val_reg[31:0];
                                end
                                res.last   = 1'b1;
                                res.used   = used_next;
                                res_push   = 1'b1;
                                state_next = S_IDLE;
                                if (count_only_reg)
                                begin
                                    res.data  = '0;
                                    res.valid = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            S_FIX:
            begin
                if (!res_full)
                begin
                    // room and remaining count drop together, so checking before
                    // each byte equals the up-front check
                    if (room_reg < 32'(nfix_reg))
                    begin
                        res.last   = 1'b1;
                        res.status = 1'b1;
                        res.used   = used_reg;
                        res_push   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        used_next = used_p1;
                        room_next = room_m1;
                        sh_next   = sh_reg >> 8;
                        nfix_next = nfix_reg - 4'd1;
                        res.data  = sh_reg[7:0];
                        res.valid = 1'b1;
                        res.used  = used_p1;
                        res_push  = !count_only_reg;
                        if (nfix_reg == 4'd1)
                        begin
                            res.last   = 1'b1;
                            res_push   = 1'b1;
                            state_next = S_IDLE;
                            if (count_only_reg)
                            begin
                                res.data  = '0;
                                res.valid = 1'b0;
                            end
                        end
                    end
                end
            end
            S_ERR:
            begin
                if (!res_full)
                begin
                    res.last   = 1'b1;
                    res.status = 1'b1;
                    res.used   = used_reg;
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the user writes configuration only while idle; the block leaves this unchecked
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CAPACITY:
                begin
                    cap_next  = cfg_data;
                    room_next = (cfg_data >= used_reg) ? cfg_data - used_reg : '0;
                end
                CFG_COUNT_ONLY:
                begin
                    count_only_next = cfg_data[0];
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            room_reg       <= '0;
            cap_reg        <= '0;
            count_only_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            room_reg       <= room_next;
            cap_reg        <= cap_next;
            count_only_reg <= count_only_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sh_reg   <= sh_next;
        val_reg  <= val_next;
        nfix_reg <= nfix_next;
    end

endmodule
`default_nettype wire

// ----- rtl/pfe_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_out_fifo
// Result queue between the byte sequencer and the result port.
// ----------------------------------------------------------------------------
module pfe_out_fifo
    import pfe_pkg::*;
#(
    parameter int Depth = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  res_t      din,
    output logic      full,
    output logic      empty,
    input  wire logic pop,
    output res_t      dout
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    res_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- verif/protobuf_field_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_encoder_tb
// Self-checking bench for the field encoder. A table of directed fields covers
// every type code, the value extremes, capacity overflow, a capacity lowered
// below the running count and count-only mode. Random fields follow under
// several register settings. Every byte or closing result is checked against
// the in-bench encoder model or a directed row's typed result, with random idle
// cycles on both queue ports and one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module protobuf_field_encoder_tb
    import pfe_pkg::*;
();

    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          IDLE_GAP        = 20;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          RAND_PHASES     = 8;
    localparam int          FIELDS_PER_PHASE = 29;
    localparam int          PRESSURE_PHASE  = 2;
    localparam logic [31:0] CAP_MAX         = 32'hFFFF_FFFF;
    localparam logic [4:0]  FT_UNKNOWN_TOP  = 5'd31;

    typedef struct packed {
        logic        restart;
        logic [4:0]  ftype;
        logic [28:0] number;
        logic        omit;
        logic [63:0] value;
    } field_t;

    // A row with a closing result in exp (last set) is checked against it as
    // typed; any other row is checked against the encoder model.
    typedef struct packed {
        logic [31:0] cap;
        logic        count_only;
        field_t      fld;
        res_t        exp;
    } row_t;

    localparam res_t NO_RES = '0;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 push;
    logic                 full;
    logic                 restart;
    logic [4:0]           field_type;
    logic [28:0]          field_number;
    logic                 omit_key;
    logic [63:0]          value_bits;
    logic                 empty;
    logic                 pop;
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 last;
    logic                 status;
    logic [31:0]          bytes_used;

    // Encoder model state
    logic [31:0] cap_q;
    logic        count_only_q;
    logic [31:0] used_q;
    res_t        field_res[$];
    res_t        expected_q[$];
    row_t        dir_rows[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int stall_left;
    int cycle_count;
    int fields_sent;
    int results_checked;
    int overflows_checked;
    int mismatches;

    protobuf_field_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .restart     (restart),
        .field_type  (field_type),
        .field_number(field_number),
        .omit_key    (omit_key),
        .value_bits  (value_bits),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .status      (status),
        .bytes_used  (bytes_used)
    );

    always #1 clk = ~clk;

    function automatic res_t mk_res(logic [7:0] d, logic v, logic l, logic s,
                                    logic [31:0] u);
        res_t r;
        r.data   = d;
        r.valid  = v;
        r.last   = l;
        r.status = s;
        r.used   = u;
        return r;
    endfunction

    function automatic res_t closing_res(logic st, logic [31:0] u);
        return mk_res(8'h00, 1'b0, 1'b1, st, u);
    endfunction

    function automatic field_t fld(logic r, logic [4:0] ty, logic [28:0] num, logic om,
                                   logic [63:0] val);
        field_t f;
        f.restart = r;
        f.ftype   = ty;
        f.number  = num;
        f.omit    = om;
        f.value   = val;
        return f;
    endfunction

    function automatic logic [31:0] room_left();
        return (cap_q >= used_q) ? cap_q - used_q : 32'd0;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 25;
            default: return 60;
        endcase
    endfunction

    task automatic add_row(input logic [31:0] cap, input logic co, input field_t f,
                           input res_t exp);
        row_t r;
        r.cap        = cap;
        r.count_only = co;
        r.fld        = f;
        r.exp        = exp;
        dir_rows.push_back(r);
    endtask

    task automatic emit_byte(input logic [7:0] b);
        used_q = used_q + 32'd1;
        if (!count_only_q)
            field_res.push_back(mk_res(b, 1'b1, 1'b0, 1'b0, used_q));
    endtask

    // Base-128, one byte of room per byte; stop where room runs out
    task automatic emit_varint(input logic [63:0] v, output bit ok);
        ok = 1'b1;
        forever
        begin
            if (room_left() == 32'd0)
            begin
                ok = 1'b0;
                break;
            end
            emit_byte((v > 64'd127) ? {1'b1, v[6:0]} : {1'b0, v[6:0]});
            v = v >> 7;
            if (v == 64'd0)
                break;
        end
    endtask

    task automatic emit_fixed(input logic [63:0] v, input int nbytes, output bit ok);
        int i;
        ok = (room_left() >= nbytes);
        if (ok)
            for (i = 0; i < nbytes; i++)
                emit_byte(v[8*i +: 8]);
    endtask

    // Work out every result one field causes and advance the byte count
    task automatic encode_field(input field_t f);
        logic [63:0] wv;
        logic [31:0] lo;
        logic [2:0]  wt;
        bit          ok;
        res_t        tail;
        field_res.delete();
        lo = f.value[31:0];
        if (f.restart)
            used_q = 32'd0;
        case (f.ftype)
            FT_DOUBLE, FT_FIXED64, FT_SFIXED64:
            begin
                wt = WT_FIX64;
                wv = f.value;
            end
            FT_INT32, FT_ENUM:
            begin
                wt = WT_VAR;
                wv = {{32{lo[31]}}, lo};
            end
            FT_UINT32:
            begin
                wt = WT_VAR;
                wv = {32'd0, lo};
            end
            FT_SINT32:
            begin
                wt = WT_VAR;
                wv = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
            end
            FT_INT64, FT_UINT64:
            begin
                wt = WT_VAR;
                wv = f.value;
            end
            FT_SINT64:
            begin
                wt = WT_VAR;
                wv = {f.value[62:0], 1'b0} ^ {64{f.value[63]}};
            end
            FT_BOOL:
            begin
                wt = WT_VAR;
                wv = {56'd0, f.value[7:0]};
            end
            FT_STRING, FT_BYTES, FT_MESSAGE:
            begin
                wt = WT_LEN;
                wv = f.value;
            end
            FT_FLOAT, FT_FIXED32, FT_SFIXED32:
            begin
                wt = WT_FIX32;
                wv = {32'd0, lo};
            end
            default:
            begin
                // unknown codes go out as a zero 4-byte value
                wt = WT_FIX32;
                wv = 64'd0;
            end
        endcase

        ok = 1'b1;
        if (!f.omit)
            emit_varint({32'd0, f.number, wt}, ok);
        if (ok)
        begin
            case (wt)
                WT_VAR:   emit_varint(wv, ok);
                WT_FIX64: emit_fixed(wv, 8, ok);
                WT_FIX32: emit_fixed(wv, 4, ok);
                default:
                begin
                    emit_varint(wv, ok);
                    // payload is reserved whole or not at all
                    if (ok)
                    begin
                        if ({32'd0, room_left()} < wv)
                            ok = 1'b0;
                        else
                            used_q = used_q + wv[31:0];
                    end
                end
            endcase
        end

        if (count_only_q || !ok)
            field_res.push_back(closing_res(!ok, used_q));
        else
        begin
            // mark the final byte and fold in the reserved payload
            tail = field_res.pop_back();
            tail.last = 1'b1;
            tail.used = used_q;
            field_res.push_back(tail);
        end
    endtask

    // Offer one field and hold it until the block takes it
    task automatic send_field(input field_t f, input res_t exp);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        restart      <= f.restart;
        field_type   <= f.ftype;
        field_number <= f.number;
        omit_key     <= f.omit;
        value_bits   <= f.value;
        do
            @(posedge clk);
        while (full);
        encode_field(f);
        if (exp.last)
        begin
            field_res.delete();
            field_res.push_back(exp);
        end
        foreach (field_res[i])
            expected_q.push_back(field_res[i]);
        fields_sent++;
    endtask

    task automatic drain_block();
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic load_regs(input logic [31:0] cap, input logic co);
        drain_block();
        cfg_write <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap;
        @(posedge clk);
        cap_q      = cap;
        cfg_index <= CFG_COUNT_ONLY;
        cfg_data  <= {31'd0, co};
        @(posedge clk);
        count_only_q = co;
        cfg_write   <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d (cycle %0d): %s", results_checked, cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_result();
        res_t want;
        results_checked++;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transfer byte %h used %0d",
                                      out_byte, bytes_used));
            return;
        end
        want = expected_q.pop_front();
        if (want.status)
            overflows_checked++;
        if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
        if (byte_valid !== want.valid)
            report_mismatch($sformatf("byte_valid %b, want %b", byte_valid, want.valid));
        if (last !== want.last)
            report_mismatch($sformatf("last %b, want %b", last, want.last));
        if (status !== want.status)
            report_mismatch($sformatf("status %b, want %b", status, want.status));
        if (bytes_used !== want.used)
            report_mismatch($sformatf("bytes_used %0d, want %0d", bytes_used, want.used));
    endtask

    // Result side: check each transfer, then decide whether to take the next
    always @(posedge clk)
    begin
        if (pop && !empty)
            check_result();
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap(rx_idle_pct);
            pop <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout at cycle %0d with %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        field_t      f;
        logic [31:0] cap;
        logic        co;
        int          ph;

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_CAPACITY;
        cfg_data     = 32'd0;
        push         = 1'b0;
        restart      = 1'b0;
        field_type   = FT_DOUBLE;
        field_number = 29'd0;
        omit_key     = 1'b0;
        value_bits   = 64'd0;
        pop          = 1'b0;
        cap_q        = 32'd0;
        count_only_q = 1'b0;
        used_q       = 32'd0;
        tx_idle_pct  = 30;
        rx_idle_pct  = 30;
        hold_left    = 0;
        stall_left   = 0;
        cycle_count  = 0;
        fields_sent  = 0;
        results_checked   = 0;
        overflows_checked = 0;
        mismatches   = 0;

        // After reset the capacity is zero: everything overflows at once
        add_row(32'd0, 1'b0, fld(1'b0, FT_UINT32, 29'd1, 1'b0, 64'd0), closing_res(1'b1, 0));
        add_row(32'd0, 1'b0, fld(1'b0, FT_FLOAT, 29'h1FFF_FFFF, 1'b1, 64'hFFFF_FFFF),
                closing_res(1'b1, 0));
        // Maximum room: most types, extremes of the value and the key
        add_row(CAP_MAX, 1'b0, fld(1'b1, FT_UINT64, 29'h1FFF_FFFF, 1'b0, '1), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_INT32, 29'd2, 1'b0, 64'h8000_0000), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SINT32, 29'd3, 1'b0, '1), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SINT32, 29'd4, 1'b0, 64'h8000_0000), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SINT64, 29'd5, 1'b0, 64'h8000_0000_0000_0000),
                NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SINT64, 29'd6, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF),
                NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_DOUBLE, 29'd7, 1'b0, 64'h0123_4567_89AB_CDEF),
                NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_FIXED32, 29'd8, 1'b0, 64'hDEAD_BEEF_89AB_CDEF),
                NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SFIXED32, 29'd9, 1'b1, 64'h8000_0000), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_SFIXED64, 29'd15, 1'b0, 64'h8000_0000_0000_0001),
                NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_BOOL, 29'd16, 1'b0, 64'h1FF), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_ENUM, 29'd127, 1'b0, 64'hFFFF_FFFF), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_INT64, 29'd0, 1'b1, 64'd0), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_STRING, 29'd2047, 1'b0, 64'd5), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_BYTES, 29'd1, 1'b0, 64'd0), NO_RES);
        // payload length beyond any 32-bit room
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_MESSAGE, 29'd1, 1'b0, 64'h1_0000_0000), NO_RES);
        add_row(CAP_MAX, 1'b0, fld(1'b0, FT_UNKNOWN_TOP, 29'd1, 1'b0, '1), NO_RES);
        // Count only: one closing result per field
        add_row(CAP_MAX, 1'b1, fld(1'b1, FT_UINT64, 29'h1FFF_FFFF, 1'b0, '1),
                closing_res(1'b0, 15));
        add_row(CAP_MAX, 1'b1, fld(1'b1, FT_STRING, 29'd1, 1'b0, 64'd100),
                closing_res(1'b0, 102));
        // Tight room: exact fit, then key and varint cut short, fixed refused
        add_row(32'd3, 1'b0, fld(1'b1, FT_UINT32, 29'd1, 1'b0, 64'd300), NO_RES);
        add_row(32'd3, 1'b0, fld(1'b0, FT_UINT32, 29'd1, 1'b0, 64'd0), closing_res(1'b1, 3));
        add_row(32'd3, 1'b0, fld(1'b1, FT_FIXED32, 29'd1, 1'b0, 64'h55), NO_RES);
        add_row(32'd3, 1'b0, fld(1'b1, FT_UINT64, 29'd1, 1'b0, 64'hFFFF), NO_RES);
        // Capacity lowered below the count already used
        add_row(32'd1, 1'b0, fld(1'b0, FT_BOOL, 29'd2, 1'b0, 64'd1), closing_res(1'b1, 3));
        add_row(32'd2, 1'b1, fld(1'b1, FT_FIXED64, 29'd1, 1'b0, 64'd0), closing_res(1'b1, 1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cap !== cap_q || dir_rows[i].count_only !== count_only_q)
                load_regs(dir_rows[i].cap, dir_rows[i].count_only);
            send_field(dir_rows[i].fld, dir_rows[i].exp);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(3))
                0:       cap = CAP_MAX;
                1:       cap = $urandom_range(60);
                2:       cap = $urandom_range(2000, 61);
                default: cap = $urandom;
            endcase
            co = ($urandom_range(3) == 0);
            if (ph == PRESSURE_PHASE)
            begin
                cap = CAP_MAX;
                co  = 1'b0;
            end
            load_regs(cap, co);
            tx_idle_pct = pick_pct();
            rx_idle_pct = pick_pct();
            // stop taking results while fields keep coming, so the block backs up
            if (ph == PRESSURE_PHASE)
            begin
                tx_idle_pct = 0;
                hold_left   = HOLD_CYCLES;
            end
            repeat (FIELDS_PER_PHASE)
            begin
                f = fld(($urandom_range(7) == 0), FT_DOUBLE, 29'($urandom),
                        ($urandom_range(3) == 0), {$urandom, $urandom});
                case ($urandom_range(19))
                    18, 19:  f.ftype = 5'($urandom_range(FT_UNKNOWN_TOP, FT_MESSAGE + 1));
                    default: f.ftype = 5'($urandom_range(FT_MESSAGE));
                endcase
                if ($urandom_range(3) != 0)
                    f.number = f.number >> $urandom_range(28);
                if ($urandom_range(3) != 0)
                    f.value = f.value >> $urandom_range(63);
                // mostly payload lengths that can fit
                if (f.ftype >= FT_STRING && f.ftype <= FT_MESSAGE && $urandom_range(7) != 0)
                    f.value = 64'($urandom_range(300));
                send_field(f, NO_RES);
            end
        end

        drain_block();
        $display("Sent %0d fields (%0d from the directed table) over %0d register settings",
                 fields_sent, dir_rows.size(), RAND_PHASES + 6);
        $display("Checked %0d results, %0d of them overflow closings; %0d mismatches",
                 results_checked, overflows_checked, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- protobuf_field_encoder.f -----
rtl/pfe_pkg.sv
rtl/pfe_front.sv
rtl/pfe_back.sv
rtl/pfe_out_fifo.sv
rtl/protobuf_field_encoder.sv
verif/protobuf_field_encoder_tb.sv
